// ===== src/brf_pkg.sv =====
// Shared types and constants for the byte ring FIFO with flush on overflow.
// No dependencies; imported by every module of the block.
`default_nettype none
package brf_pkg;

   localparam int unsigned KIND_W = 2;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned FILL_W = 11;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef struct packed {
      logic              pop_rd;
      status_type        status;
      logic [FILL_W-1:0] fill;
   } step_type;

endpackage
`default_nettype wire

// ===== src/brf_ram.sv =====
// Single-port-write, single-port-read byte memory with registered read data.
// Depends on brf_pkg for the byte width.
`default_nettype none
module brf_ram #(
   parameter int unsigned AW = 11
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [brf_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [brf_pkg::BYTE_W-1:0] rd_data
);
   import brf_pkg::*;

   logic [BYTE_W-1:0] mem [2**AW];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/brf_ptr.sv =====
// Write and read pointers, full/empty decisions and memory access requests.
// Depends on brf_pkg for command, status and step types.
`default_nettype none
module brf_ptr #(
   parameter int unsigned AW = 11
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [brf_pkg::KIND_W-1:0] kind,
   input  wire logic [brf_pkg::BYTE_W-1:0] push_byte,
   output logic                            wr_en,
   output logic      [AW-1:0]              wr_addr,
   output logic      [brf_pkg::BYTE_W-1:0] wr_data,
   output logic                            rd_en,
   output logic      [AW-1:0]              rd_addr,
   output brf_pkg::step_type               step
);
   import brf_pkg::*;

   logic [AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]        wr_next, rd_next, diff;
   logic [AW+FILL_W-1:0] diff_ext;
   logic                 full, empty, do_wr, do_rd;
   status_type           status;

   always_comb begin
      wr_next   = wr_ptr_ff + AW'(1);
      rd_next   = rd_ptr_ff + AW'(1);
      full      = (wr_next == rd_ptr_ff);
      empty     = (wr_ptr_ff == rd_ptr_ff);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      do_wr     = 1'b0;
      do_rd     = 1'b0;
      status    = ST_OK;
      case (kind_type'(kind))
         KIND_PUSH: begin
            if (full) begin
               wr_ptr_in = '0;
               rd_ptr_in = '0;
               status    = ST_OVERFLOW;
            end else begin
               do_wr     = 1'b1;
               wr_ptr_in = wr_next;
            end
         end
         KIND_POP: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               do_rd     = 1'b1;
               rd_ptr_in = rd_next;
            end
         end
         KIND_CLEAR: begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
         end
         default: begin
         end
      endcase
      diff     = wr_ptr_in - rd_ptr_in;
      diff_ext = {{FILL_W{1'b0}}, diff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else if (accept) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   assign wr_en       = accept & do_wr;
   assign wr_addr     = wr_ptr_ff;
   assign wr_data     = push_byte;
   assign rd_en       = accept & do_rd;
   assign rd_addr     = rd_ptr_ff;
   assign step.pop_rd = do_rd;
   assign step.status = status;
   assign step.fill   = diff_ext[FILL_W-1:0];

endmodule
`default_nettype wire

// ===== src/byte_ring_fifo_flush_on_overflow.sv =====
// Byte ring FIFO that flushes on overflow: top level with handshake and result stages.
// Depends on brf_pkg, brf_ptr and brf_ram.
//
// Takes one push, pop, clear or no-op command per cycle while req_stall is low and returns
// one result per command, in order, through the s1 stage and the output register. Pointers
// are decided in the transfer cycle; a pop reads the byte memory then, and the registered read
// data joins the status and fill count in the following stage before the output register.
// A full FIFO holds 2**AW-1 bytes, DEPTH-1 when DEPTH is a power of two. The memory needs no
// clearing after reset: a pop only reads slots written since the last flush.
`default_nettype none
module byte_ring_fifo_flush_on_overflow #(
   parameter int unsigned DEPTH = 2048
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [brf_pkg::KIND_W-1:0] req_kind,
   input  wire logic [brf_pkg::BYTE_W-1:0] req_push_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [brf_pkg::STAT_W-1:0] rsp_status,
   output logic      [brf_pkg::BYTE_W-1:0] rsp_pop_byte,
   output logic      [brf_pkg::FILL_W-1:0] rsp_fill_count
);
   import brf_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   logic              accept, s1_move;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;
   step_type          step;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_pop_ff;
   status_type        s1_status_ff;
   logic [FILL_W-1:0] s1_fill_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [BYTE_W-1:0] rsp_pop_byte_ff;
   logic [FILL_W-1:0] rsp_fill_count_ff;

   brf_ptr #(.AW(AW)) u_ptr (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .push_byte (req_push_byte),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .step      (step)
   );

   brf_ram #(.AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_move      = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
      req_stall    = s1_valid_ff & ~s1_move;
      accept       = req_valid & ~req_stall;
      s1_valid_in  = accept | (s1_valid_ff & ~s1_move);
      rsp_valid_in = s1_move | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pop_ff    <= step.pop_rd;
         s1_status_ff <= step.status;
         s1_fill_ff   <= step.fill;
      end
      if (s1_move) begin
         rsp_status_ff     <= s1_status_ff;
         rsp_pop_byte_ff   <= s1_pop_ff ? rd_data : '0;
         rsp_fill_count_ff <= s1_fill_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pop_byte   = rsp_pop_byte_ff;
   assign rsp_fill_count = rsp_fill_count_ff;

   a_clear_zero_fill: assert property (@(posedge clock) disable iff (reset)
      accept && (kind_type'(req_kind) == KIND_CLEAR) |=> (s1_fill_ff == '0))
      else $error("clear did not report an empty FIFO");

   a_overflow_flush: assert property (@(posedge clock) disable iff (reset)
      accept && (step.status == ST_OVERFLOW) |=> (s1_fill_ff == '0) && !s1_pop_ff)
      else $error("overflow did not flush the FIFO");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_fill_ff)
         && $stable(s1_status_ff))
      else $error("pending result overwritten while output stalled");

   a_no_pop_data: assert property (@(posedge clock) disable iff (reset)
      s1_move && !s1_pop_ff |=> (rsp_pop_byte_ff == '0))
      else $error("non-pop result carries data");

endmodule
`default_nettype wire
